// File: src/least_loaded_server_dispatch_assert.svh
// assertion macros for least_loaded_server_dispatch
`ifndef LEAST_LOADED_SERVER_DISPATCH_ASSERT_SVH
`define LEAST_LOADED_SERVER_DISPATCH_ASSERT_SVH

`ifndef ASSERT_OFF
`define LLSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("least_loaded_server_dispatch: assertion failed");
`define LLSD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("least_loaded_server_dispatch: reset assertion failed");
`else
`define LLSD_ASSERT(lbl, prop)
`define LLSD_ASSERT_RST(lbl, prop)
`endif

`endif

// File: src/llsd_pkg.sv
package llsd_pkg;

  localparam int unsigned TIME_W = 20;
  localparam int unsigned LOAD_W = 32;
  localparam int unsigned SRV_W  = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  localparam logic KIND_CUSTOMER = 1'b0;
  localparam logic KIND_CLEAR    = 1'b1;

  localparam logic [ADDR_W-3:0] REG_SERVERS_IN_USE = '0;
  localparam logic [SRV_W-1:0]  SERVERS_IN_USE_RST = SRV_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } llsd_state_e;

endpackage

// File: src/least_loaded_server_dispatch.sv
// Least-loaded server dispatch.
// Input channel (in_valid_i / in_stall_o) carries one request: kind_i and
// service_time_i. A customer request goes to the active server with the
// smallest accumulated load (lowest number on a tie) and adds its service
// time to that load, saturating at all ones. A clear request zeroes all loads.
// Output channel (out_valid_o / out_stall_i) gives one result per request:
// assigned_server_o, next_server_o and saturated_o.
// Loads sit in a memory of MAX_SERVERS words with one read and one write
// port; one comparator walks the active servers, one entry per cycle.
// A clear request goes straight to the output register. A customer request
// updates the load of the cached minimum, then rescans for the new minimum;
// after a servers_in_use write, a scan finds the minimum before the update.
// Only one request is in flight; in_stall_o is high until its result is in
// the output register. A stalled result holds; the next request is taken.
// Reset: all loads read as zero, servers_in_use is 1, no result is pending.
// The user must write servers_in_use over the APB port only while no request
// is in flight; the block itself does not enforce this.
`include "least_loaded_server_dispatch_assert.svh"

module least_loaded_server_dispatch #(
  parameter int unsigned MAX_SERVERS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [llsd_pkg::TIME_W-1:0] service_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [llsd_pkg::SRV_W-1:0]  assigned_server_o,
  output logic [llsd_pkg::SRV_W-1:0]  next_server_o,
  output logic                        saturated_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llsd_pkg::ADDR_W-1:0] paddr,
  input  logic [llsd_pkg::DATA_W-1:0] pwdata,
  output logic [llsd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import llsd_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SERVERS);
  localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);

  llsd_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              scan_post_q, scan_post_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [LOAD_W-1:0] best_load_q, best_load_d;
  logic              best_vld_q, best_vld_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [SRV_W-1:0]  res_assigned_q, res_assigned_d;
  logic              res_sat_q, res_sat_d;
  logic              out_valid_q, out_valid_d;
  logic [SRV_W-1:0]  out_assigned_q, out_assigned_d;
  logic [SRV_W-1:0]  out_next_q, out_next_d;
  logic              out_sat_q, out_sat_d;
  logic [SRV_W-1:0]  su_q;

  logic [LOAD_W-1:0]      mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_q;
  logic [LOAD_W-1:0]      rd_data_q;
  logic                   rd_vld_q;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [LOAD_W-1:0]      mem_wdata;
  logic                   clr_all;

  logic [CNT_W-1:0]  n_act;
  logic [LOAD_W-1:0] cand_load;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] upd_load;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cfg_wr;
  logic              cfg_hit;

  // apb register
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_hit = (paddr[ADDR_W-1:2] == REG_SERVERS_IN_USE);
  assign prdata  = cfg_hit ? DATA_W'(su_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_q <= SERVERS_IN_USE_RST;
    end else if (cfg_wr && cfg_hit) begin
      su_q <= pwdata[SRV_W-1:0];
    end
  end

  // active server count, clamped to 1..MAX_SERVERS
  always_comb begin
    if (su_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(su_q) > MAX_SERVERS) begin
      n_act = CNT_W'(MAX_SERVERS);
    end else begin
      n_act = CNT_W'(su_q);
    end
  end

  assign rd_addr   = (cnt_q < n_act) ? cnt_q[IDX_W-1:0] : '0;
  assign cand_load = rd_vld_q ? rd_data_q : '0;
  assign cmp_idx   = IDX_W'(cnt_q - CNT_W'(1));
  assign sum       = {1'b0, best_load_q} + (LOAD_W + 1)'(time_q);
  assign upd_load  = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  assign mem_wdata = upd_load;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    scan_post_d    = scan_post_q;
    best_d         = best_q;
    best_load_d    = best_load_q;
    best_vld_d     = best_vld_q;
    time_d         = time_q;
    res_assigned_d = res_assigned_q;
    res_sat_d      = res_sat_q;
    out_valid_d    = out_valid_q & out_stall_i;
    out_assigned_d = out_assigned_q;
    out_next_d     = out_next_q;
    out_sat_d      = out_sat_q;
    mem_we         = 1'b0;
    clr_all        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_wr) begin
          best_vld_d = 1'b0;
        end
        if (in_valid_i) begin
          if (kind_i == KIND_CLEAR) begin
            clr_all        = 1'b1;
            best_d         = '0;
            best_load_d    = '0;
            best_vld_d     = 1'b1;
            res_assigned_d = '0;
            res_sat_d      = 1'b0;
            state_d        = ST_DONE;
          end else begin
            time_d = service_time_i;
            if (best_vld_q) begin
              state_d = ST_UPDATE;
            end else begin
              cnt_d       = '0;
              scan_post_d = 1'b0;
              state_d     = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // read data is registered, so it belongs to the previous counter value
        if (cnt_q != '0) begin
          if (cnt_q == CNT_W'(1) || cand_load < best_load_q) begin
            best_d      = cmp_idx;
            best_load_d = cand_load;
          end
        end
        if (cnt_q == n_act) begin
          if (scan_post_q) begin
            best_vld_d = 1'b1;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_UPDATE;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        mem_we         = 1'b1;
        res_assigned_d = SRV_W'({1'b0, best_q} + 1);
        res_sat_d      = (upd_load == LOAD_MAX);
        cnt_d          = '0;
        scan_post_d    = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_assigned_d = res_assigned_q;
          out_next_d     = SRV_W'({1'b0, best_q} + 1);
          out_sat_d      = res_sat_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      scan_post_q <= 1'b0;
      best_q      <= '0;
      best_load_q <= '0;
      best_vld_q  <= 1'b1;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_post_q <= scan_post_d;
      best_q      <= best_d;
      best_load_q <= best_load_d;
      best_vld_q  <= best_vld_d;
      out_valid_q <= out_valid_d;
      if (clr_all) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[best_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q         <= time_d;
    res_assigned_q <= res_assigned_d;
    res_sat_q      <= res_sat_d;
    out_assigned_q <= out_assigned_d;
    out_next_q     <= out_next_d;
    out_sat_q      <= out_sat_d;
  end

  // load memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[best_q] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign assigned_server_o = out_assigned_q;
  assign next_server_o     = out_next_q;
  assign saturated_o       = out_sat_q;

  `LLSD_ASSERT(a_scan_bound, state_q == ST_SCAN |-> cnt_q <= n_act)
  `LLSD_ASSERT(a_done_has_min, state_q == ST_DONE |-> best_vld_q)
  `LLSD_ASSERT(a_write_then_scan, mem_we |=> state_q == ST_SCAN && cnt_q == '0 && scan_post_q)
  `LLSD_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o)

endmodule
